// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the parser RTL. Compiled out when
// SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== design/ngga_pkg.sv =====
// ---------------------------------------------------------------------------
// ngga_pkg
// Shared types, character codes and constant tables for the GGA parser.
// ---------------------------------------------------------------------------
package ngga_pkg;

  // accumulator widths, sized for the largest supported digit counts
  localparam int INT_W   = 17;  // up to 5 integer digits
  localparam int FRAC_W  = 20;  // up to 6 fraction digits
  localparam int CNT_W   = 3;
  localparam int CHAR_W  = 8;
  localparam int COORD_W = 34;
  localparam int FIELD_W = 3;

  localparam logic [2:0] HDR_LEN = 3'd6;

  // field positions within a sentence
  localparam logic [FIELD_W-1:0] FLD_HEADER   = 3'd0;
  localparam logic [FIELD_W-1:0] FLD_TIME     = 3'd1;
  localparam logic [FIELD_W-1:0] FLD_LAT      = 3'd2;
  localparam logic [FIELD_W-1:0] FLD_LAT_HEMI = 3'd3;
  localparam logic [FIELD_W-1:0] FLD_LON      = 3'd4;
  localparam logic [FIELD_W-1:0] FLD_LON_HEMI = 3'd5;

  // character codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_A      = 8'h41;

  // command kinds passed from the front end to the converter
  typedef enum logic [1:0] {
    CMD_LAT      = 2'd0,
    CMD_LAT_HEMI = 2'd1,
    CMD_LON      = 2'd2,
    CMD_EMIT     = 2'd3
  } ngga_kind_t;

  typedef struct packed {
    ngga_kind_t             kind;
    logic [INT_W-1:0]       int_val;
    logic [FRAC_W-1:0]      frac_val;
    logic [CNT_W-1:0]       frac_cnt;
    logic [CHAR_W-1:0]      hemi;
  } ngga_cmd_t;

  // expected sentence header "$GNGGA"
  function automatic logic [7:0] hdr_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = CH_DOLLAR;
      3'd1:    c = CH_G;
      3'd2:    c = CH_N;
      3'd3:    c = CH_G;
      3'd4:    c = CH_G;
      default: c = CH_A;
    endcase
    return c;
  endfunction

  // powers of ten up to 10^7
  function automatic logic [23:0] pow10(input logic [2:0] n);
    logic [23:0] p;
    case (n)
      3'd0:    p = 24'd1;
      3'd1:    p = 24'd10;
      3'd2:    p = 24'd100;
      3'd3:    p = 24'd1000;
      3'd4:    p = 24'd10000;
      3'd5:    p = 24'd100000;
      3'd6:    p = 24'd1000000;
      default: p = 24'd10000000;
    endcase
    return p;
  endfunction

  // reciprocals: floor(y/25) = (y*RECIP25)>>20 for y < 43690,
  // floor(x/15) = (x*RECIP15)>>32 for x < 2^28
  localparam logic [15:0] RECIP25 = 16'd41944;
  localparam logic [28:0] RECIP15 = 29'd286331154;
  localparam logic [COORD_W-1:0] DEG_E7 = 34'd10000000;

endpackage

// ===== design/ngga_front.sv =====
// ---------------------------------------------------------------------------
// ngga_front
// Byte classifier: header match, field tracking and digit accumulation.
// Posts one command per finished coordinate or hemisphere field.
// ---------------------------------------------------------------------------
module ngga_front import ngga_pkg::*; #(
  parameter int MAX_INT_DIGITS  = 5,
  parameter int FRACTION_DIGITS = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output logic       push,
  output ngga_cmd_t  cmd
);

  logic [2:0]         hdr_r, hdr_nxt;
  logic [FIELD_W-1:0] field_r, field_nxt;
  logic               bad_r, bad_nxt;
  logic [INT_W-1:0]   int_r, int_nxt;
  logic [CNT_W-1:0]   int_cnt_r, int_cnt_nxt;
  logic [FRAC_W-1:0]  frac_r, frac_nxt;
  logic [CNT_W-1:0]   frac_cnt_r, frac_cnt_nxt;
  logic               point_r, point_nxt;

  logic       is_term;
  logic       is_end;
  logic       is_digit;
  logic       empty;
  logic [3:0] digit;
  ngga_kind_t kind;

  assign is_end   = rx_byte inside {CH_STAR, CH_CR, CH_LF};
  assign is_term  = is_end || (rx_byte == CH_COMMA);
  assign is_digit = rx_byte inside {[CH_0:CH_9]};
  assign digit    = 4'(rx_byte - CH_0);
  assign empty    = (int_cnt_r == '0) && (frac_cnt_r == '0);

  // command payload always reflects the field being closed
  always_comb begin
    cmd.kind     = kind;
    cmd.int_val  = int_r;
    cmd.frac_val = frac_r;
    cmd.frac_cnt = frac_cnt_r;
    cmd.hemi     = int_r[CHAR_W-1:0];
  end

  // per-byte parse step
  always_comb begin
    hdr_nxt      = hdr_r;
    field_nxt    = field_r;
    bad_nxt      = bad_r;
    int_nxt      = int_r;
    int_cnt_nxt  = int_cnt_r;
    frac_nxt     = frac_r;
    frac_cnt_nxt = frac_cnt_r;
    point_nxt    = point_r;
    push         = 1'b0;
    kind         = CMD_LAT;
    if (accept) begin
      if (rx_byte == CH_DOLLAR) begin
        // restart, even in the middle of a sentence
        hdr_nxt      = 3'd1;
        field_nxt    = FLD_HEADER;
        bad_nxt      = 1'b0;
        int_nxt      = '0;
        int_cnt_nxt  = '0;
        frac_nxt     = '0;
        frac_cnt_nxt = '0;
        point_nxt    = 1'b0;
      end else if (!bad_r) begin
        if (hdr_r < HDR_LEN) begin
          if (rx_byte == hdr_char(hdr_r)) hdr_nxt = hdr_r + 3'd1;
          else                            bad_nxt = 1'b1;
        end else if (is_term) begin
          if (field_r == FLD_LON_HEMI) begin
            bad_nxt = 1'b1;
            if (!empty) begin
              push = 1'b1;
              kind = CMD_EMIT;
            end
          end else if (is_end || ((field_r >= FLD_LAT) && empty)) begin
            bad_nxt = 1'b1;
          end else begin
            case (field_r)
              FLD_LAT: begin
                push = 1'b1;
                kind = CMD_LAT;
              end
              FLD_LAT_HEMI: begin
                push = 1'b1;
                kind = CMD_LAT_HEMI;
              end
              FLD_LON: begin
                push = 1'b1;
                kind = CMD_LON;
              end
              default: ;
            endcase
            field_nxt    = field_r + 3'd1;
            int_nxt      = '0;
            int_cnt_nxt  = '0;
            frac_nxt     = '0;
            frac_cnt_nxt = '0;
            point_nxt    = 1'b0;
          end
        end else begin
          case (field_r)
            FLD_LAT, FLD_LON: begin
              if (is_digit) begin
                if (!point_r) begin
                  if (int_cnt_r >= CNT_W'(MAX_INT_DIGITS)) begin
                    bad_nxt = 1'b1;
                  end else begin
                    int_nxt     = INT_W'(int_r * INT_W'(10) + INT_W'(digit));
                    int_cnt_nxt = int_cnt_r + 3'd1;
                  end
                end else if (frac_cnt_r < CNT_W'(FRACTION_DIGITS)) begin
                  frac_nxt     = FRAC_W'(frac_r * FRAC_W'(10) + FRAC_W'(digit));
                  frac_cnt_nxt = frac_cnt_r + 3'd1;
                end
              end else if ((rx_byte == CH_POINT) && !point_r) begin
                point_nxt = 1'b1;
              end else begin
                bad_nxt = 1'b1;
              end
            end
            FLD_LAT_HEMI, FLD_LON_HEMI: begin
              // keep the first character only
              if (int_cnt_r == '0) begin
                int_nxt     = INT_W'(rx_byte);
                int_cnt_nxt = 3'd1;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r      <= '0;
      field_r    <= FLD_HEADER;
      bad_r      <= 1'b1;
      int_r      <= '0;
      int_cnt_r  <= '0;
      frac_r     <= '0;
      frac_cnt_r <= '0;
      point_r    <= 1'b0;
    end else begin
      hdr_r      <= hdr_nxt;
      field_r    <= field_nxt;
      bad_r      <= bad_nxt;
      int_r      <= int_nxt;
      int_cnt_r  <= int_cnt_nxt;
      frac_r     <= frac_nxt;
      frac_cnt_r <= frac_cnt_nxt;
      point_r    <= point_nxt;
    end
  end

endmodule

// ===== design/ngga_cmd_fifo.sv =====
// ---------------------------------------------------------------------------
// ngga_cmd_fifo
// Small command queue between the byte classifier and the converter.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ngga_cmd_fifo import ngga_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  ngga_cmd_t wdata,
  output logic      full,
  input  logic      pop,
  output ngga_cmd_t rdata,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W_Q = $clog2(DEPTH + 1);

  ngga_cmd_t          mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W_Q-1:0] count_r;

  assign full  = (count_r == CNT_W_Q'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop)      count_r <= count_r + CNT_W_Q'(1);
      else if (pop && !push) count_r <= count_r - CNT_W_Q'(1);
    end
  end

  `ASSERT_IMPLY(a_no_overflow, clk, rst_n, push, !full || pop, "command pushed into full queue")
  `ASSERT_IMPLY(a_no_underflow, clk, rst_n, pop, !empty, "command popped from empty queue")
  `ASSERT_ALWAYS(a_count_range, clk, rst_n, count_r <= CNT_W_Q'(DEPTH), "queue count out of range")
  `ASSERT_NEXT(a_push_fills, clk, rst_n, push && !pop, !empty, "queue empty after a push")

endmodule

// ===== design/ngga_back.sv =====
// ---------------------------------------------------------------------------
// ngga_back
// Converter pipeline: turns ddmm.mmmm into 1e-7 degree units, keeps the
// latitude and longitude, and registers one result item per sentence.
// ---------------------------------------------------------------------------
module ngga_back import ngga_pkg::*; #(
  parameter int FRACTION_DIGITS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_empty,
  input  ngga_cmd_t          cmd,
  output logic               cmd_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COORD_W-1:0] out_latitude_e7,
  output logic [CHAR_W-1:0]  out_lat_hemisphere,
  output logic [COORD_W-1:0] out_longitude_e7,
  output logic [CHAR_W-1:0]  out_lon_hemisphere
);

  localparam int NSTG = 6;
  localparam logic [2:0]  F_DIG   = 3'(FRACTION_DIGITS);
  localparam logic [23:0] SCALE_F = pow10(F_DIG);        // 10^F
  localparam logic [23:0] SCALE_K = pow10(3'd7 - F_DIG); // 10^(7-F)

  typedef struct packed {
    ngga_kind_t        kind;
    logic [CHAR_W-1:0] hemi;
  } tag_t;

  logic            en;
  logic [NSTG-1:0] vld_r;
  tag_t            tag_r [NSTG];

  // stage 1: degrees = int/100, fraction scale lookup
  logic [2:0]        gap;
  logic [30:0]       div_prod;
  logic [9:0]        s1_deg_nxt, s1_deg_r;
  logic [19:0]       s1_scale_nxt, s1_scale_r;
  logic [INT_W-1:0]  s1_int_r;
  logic [FRAC_W-1:0] s1_frac_r;

  // stage 2: minutes and scaled fraction
  logic [INT_W-1:0]  s2_rem;
  logic [39:0]       s2_fprod;
  logic [6:0]        s2_min_nxt, s2_min_r;
  logic [19:0]       s2_fsc_nxt, s2_fsc_r;
  logic [9:0]        s2_deg_r;

  // stage 3: minutes as fixed point with F fraction digits, degrees * 1e7
  logic [26:0]        s3_m_nxt, s3_m_r;
  logic [COORD_W-1:0] s3_dege7_nxt, s3_dege7_r;

  // stage 4: m * 10^(7-F)
  logic [50:0]        s4_prod;
  logic [29:0]        s4_p_nxt, s4_p_r;
  logic [COORD_W-1:0] s4_dege7_r;

  // stage 5: divide by 60 as (p>>2)/15
  logic [56:0]        s5_prod;
  logic [23:0]        s5_q_nxt, s5_q_r;
  logic [COORD_W-1:0] s5_dege7_r;

  // stage 6: sum
  logic [COORD_W-1:0] s6_val_nxt, s6_val_r;

  logic [COORD_W-1:0] lat_hold_r, lon_hold_r;
  logic [CHAR_W-1:0]  lat_hemi_r;
  logic               out_valid_r;
  logic [COORD_W-1:0] out_lat_r, out_lon_r;
  logic [CHAR_W-1:0]  out_lat_hemi_r, out_lon_hemi_r;

  // whole pipeline advances unless a result waits and is stalled
  assign en      = !(out_valid_r && out_stall);
  assign cmd_pop = en && !cmd_empty;

  always_comb begin
    gap          = (cmd.frac_cnt <= F_DIG) ? (F_DIG - cmd.frac_cnt) : 3'd0;
    div_prod     = 31'(cmd.int_val[INT_W-1:2]) * 31'(RECIP25);
    s1_deg_nxt   = div_prod[29:20];
    s1_scale_nxt = 20'(pow10(gap));

    s2_rem       = s1_int_r - INT_W'(17'(s1_deg_r) * 17'd100);
    s2_min_nxt   = s2_rem[6:0];
    s2_fprod     = 40'(s1_frac_r) * 40'(s1_scale_r);
    s2_fsc_nxt   = s2_fprod[19:0];

    s3_m_nxt     = 27'(27'(s2_min_r) * 27'(SCALE_F)) + 27'(s2_fsc_r);
    s3_dege7_nxt = COORD_W'(COORD_W'(s2_deg_r) * DEG_E7);

    s4_prod      = 51'(s3_m_r) * 51'(SCALE_K);
    s4_p_nxt     = s4_prod[29:0];

    s5_prod      = 57'(s4_p_r[29:2]) * 57'(RECIP15);
    s5_q_nxt     = s5_prod[55:32];

    s6_val_nxt   = s5_dege7_r + COORD_W'(s5_q_r);
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], cmd_pop};
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0].kind <= cmd.kind;
      tag_r[0].hemi <= cmd.hemi;
      for (int i = 1; i < NSTG; i++) tag_r[i] <= tag_r[i-1];
      s1_deg_r   <= s1_deg_nxt;
      s1_scale_r <= s1_scale_nxt;
      s1_int_r   <= cmd.int_val;
      s1_frac_r  <= cmd.frac_val;
      s2_min_r   <= s2_min_nxt;
      s2_fsc_r   <= s2_fsc_nxt;
      s2_deg_r   <= s1_deg_r;
      s3_m_r     <= s3_m_nxt;
      s3_dege7_r <= s3_dege7_nxt;
      s4_p_r     <= s4_p_nxt;
      s4_dege7_r <= s3_dege7_r;
      s5_q_r     <= s5_q_nxt;
      s5_dege7_r <= s4_dege7_r;
      s6_val_r   <= s6_val_nxt;
    end
  end

  // coordinate holds, updated in command order at the last stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_hold_r <= '0;
      lat_hemi_r <= '0;
      lon_hold_r <= '0;
    end else if (en && vld_r[NSTG-1]) begin
      case (tag_r[NSTG-1].kind)
        CMD_LAT:      lat_hold_r <= s6_val_r;
        CMD_LAT_HEMI: lat_hemi_r <= tag_r[NSTG-1].hemi;
        CMD_LON:      lon_hold_r <= s6_val_r;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[NSTG-1] && (tag_r[NSTG-1].kind == CMD_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld_r[NSTG-1] && (tag_r[NSTG-1].kind == CMD_EMIT)) begin
      out_lat_r      <= lat_hold_r;
      out_lat_hemi_r <= lat_hemi_r;
      out_lon_r      <= lon_hold_r;
      out_lon_hemi_r <= tag_r[NSTG-1].hemi;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_latitude_e7    = out_lat_r;
  assign out_lat_hemisphere = out_lat_hemi_r;
  assign out_longitude_e7   = out_lon_r;
  assign out_lon_hemisphere = out_lon_hemi_r;

endmodule

// ===== design/nmea_gga_position_parser.sv =====
// ---------------------------------------------------------------------------
// nmea_gga_position_parser
// Extracts latitude and longitude from $GNGGA sentences of an NMEA stream.
// ---------------------------------------------------------------------------
// One received character is taken per cycle while in_stall is low. The
// front end classifies each character in the cycle it arrives and posts
// a command for every finished latitude, longitude or hemisphere field
// into a 4-entry queue; a 6-stage converter pipeline turns the coordinates
// into 1e-7 degree units. The command for the E/W field passes the queue,
// the converter stages and the result register. in_stall rises only when
// the queue fills, only after out_stall has held back a waiting result.
module nmea_gga_position_parser import ngga_pkg::*; #(
  parameter int MAX_INT_DIGITS  = 5,
  parameter int FRACTION_DIGITS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COORD_W-1:0] out_latitude_e7,
  output logic [CHAR_W-1:0]  out_lat_hemisphere,
  output logic [COORD_W-1:0] out_longitude_e7,
  output logic [CHAR_W-1:0]  out_lon_hemisphere
);

  localparam int QUEUE_DEPTH = 4;

  logic      accept;
  logic      push, pop, full, empty;
  ngga_cmd_t wcmd, rcmd;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  ngga_front #(
    .MAX_INT_DIGITS  (MAX_INT_DIGITS),
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_rx_byte),
    .push    (push),
    .cmd     (wcmd)
  );

  ngga_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (wcmd),
    .full  (full),
    .pop   (pop),
    .rdata (rcmd),
    .empty (empty)
  );

  ngga_back #(
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_empty          (empty),
    .cmd                (rcmd),
    .cmd_pop            (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_latitude_e7    (out_latitude_e7),
    .out_lat_hemisphere (out_lat_hemisphere),
    .out_longitude_e7   (out_longitude_e7),
    .out_lon_hemisphere (out_lon_hemisphere)
  );

endmodule
